// File: rtl/m7ds_pkg.sv
package m7ds_pkg;

   localparam int PLANE_MAX   = 65536;
   localparam int RING_DEPTH  = 2 * PLANE_MAX;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int SAMPLE_W    = 16;
   localparam int SIZE_W      = 11;
   localparam int POS_W       = 10;
   localparam int SIZE_LIMIT  = 1024;
   localparam int RD_PORTS    = 6;
   localparam int MED_TAPS    = 7;
   localparam int MED_RANK    = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IW      = 2;

   localparam logic [CSR_IW-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_SIZE_Z = 2'd2;

   // axis that carries the odd (trigger) coordinate
   localparam logic [1:0] AX_X    = 2'd0;
   localparam logic [1:0] AX_Y    = 2'd1;
   localparam logic [1:0] AX_Z    = 2'd2;
   localparam logic [1:0] AX_NONE = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]          sample;
      logic                                has_res;
      logic                                last;
      logic                                all_cur;
      logic [RING_AW-1:0]                  wr_addr;
      logic [RD_PORTS-1:0][RING_AW-1:0]    rd_addr;
   } entry_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > SIZE_W'(SIZE_LIMIT)) r = SIZE_W'(SIZE_LIMIT);
      return r;
   endfunction

   function automatic logic [POS_W-1:0] half_size(input logic [SIZE_W-1:0] n);
      logic [POS_W-1:0] r;
      r = n[SIZE_W-1:1];
      if (r == '0) r = POS_W'(1);
      return r;
   endfunction

endpackage

// File: rtl/m7ds_queue.sv
module m7ds_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  m7ds_pkg::entry_type   push_entry,
   input  logic                  pop,
   output m7ds_pkg::entry_type   head_entry,
   output logic                  not_empty,
   output logic                  full
);
   import m7ds_pkg::*;

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign head_entry = slot_ff[rd_ptr_ff];
   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QUEUE_CW'(1);
      else if (pop && !push) count_in = count_ff - QUEUE_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: rtl/m7ds_front.sv
module m7ds_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [m7ds_pkg::CSR_IW-1:0]            csr_index,
   input  logic [m7ds_pkg::SIZE_W-1:0]            csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [m7ds_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                   q_full,
   output logic                                   push,
   output m7ds_pkg::entry_type                    push_entry
);
   import m7ds_pkg::*;

   logic [SIZE_W-1:0]   size_x_ff, size_x_in;
   logic [SIZE_W-1:0]   size_y_ff, size_y_in;
   logic [SIZE_W-1:0]   size_z_ff, size_z_in;
   logic                settle_ff;

   // derived geometry, registered from the current size registers
   logic [1:0]          ax_ff, ax_in;
   logic [POS_W-1:0]    nm1_ff [3];
   logic [POS_W-1:0]    nm1_in [3];
   logic [POS_W-1:0]    h_ff [3];
   logic [POS_W-1:0]    h_in [3];
   logic [POS_W-1:0]    hm1_ff [3];
   logic [POS_W-1:0]    hm1_in [3];
   logic [RING_AW-1:0]  d_s_ff, d_2s_ff, d_sp1_ff, d_sm1_ff, d_spx_ff, d_smx_ff;
   logic [RING_AW-1:0]  d_s_in, d_2s_in, d_sp1_in, d_sm1_in, d_spx_in, d_smx_in;

   logic [SIZE_W-1:0]   nx, ny, nz;
   logic [2*SIZE_W-1:0] sxy;

   logic [POS_W-1:0]    pos_ff [3];
   logic [POS_W-1:0]    pos_in [3];
   logic [RING_AW-1:0]  ring_ptr_ff, ring_ptr_in;

   logic [2:0]          odd_req, ok, at_last, lo_ok, hi_ok;
   logic                ax_lo_ok;
   logic [RING_AW-1:0]  rd_dist [RD_PORTS];

   assign req_ready = !q_full && !settle_ff;
   assign push      = req_valid && req_ready;

   // configuration registers
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X: size_x_in = csr_wdata;
            CSR_SIZE_Y: size_y_in = csr_wdata;
            CSR_SIZE_Z: size_z_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // geometry from the current sizes
   always_comb begin
      nx  = eff_size(size_x_ff);
      ny  = eff_size(size_y_ff);
      nz  = eff_size(size_z_ff);
      sxy = nx * ny;
      if (nz >= SIZE_W'(2))      ax_in = AX_Z;
      else if (ny >= SIZE_W'(2)) ax_in = AX_Y;
      else if (nx >= SIZE_W'(2)) ax_in = AX_X;
      else                       ax_in = AX_NONE;
      case (ax_in)
         AX_Z:    d_s_in = sxy[RING_AW-1:0];
         AX_Y:    d_s_in = RING_AW'(nx);
         AX_X:    d_s_in = RING_AW'(1);
         default: d_s_in = '0;
      endcase
      d_2s_in  = d_s_in << 1;
      d_sp1_in = d_s_in + RING_AW'(1);
      d_sm1_in = d_s_in - RING_AW'(1);
      d_spx_in = d_s_in + RING_AW'(nx);
      d_smx_in = d_s_in - RING_AW'(nx);
      nm1_in[0] = POS_W'(nx - SIZE_W'(1));
      nm1_in[1] = POS_W'(ny - SIZE_W'(1));
      nm1_in[2] = POS_W'(nz - SIZE_W'(1));
      h_in[0]   = half_size(nx);
      h_in[1]   = half_size(ny);
      h_in[2]   = half_size(nz);
      hm1_in[0] = h_in[0] - POS_W'(1);
      hm1_in[1] = h_in[1] - POS_W'(1);
      hm1_in[2] = h_in[2] - POS_W'(1);
   end

   // classify the voxel at the current position
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         odd_req[a] = (ax_ff == 2'(a));
         ok[a]      = (pos_ff[a][0] == odd_req[a]) &&
                      (odd_req[a] || ({1'b0, pos_ff[a][POS_W-1:1]} < h_ff[a]));
         at_last[a] = ({1'b0, pos_ff[a][POS_W-1:1]} == hm1_ff[a]);
         lo_ok[a]   = odd_req[a] ? (pos_ff[a][POS_W-1:1] != '0) : (pos_ff[a] != '0);
         hi_ok[a]   = (pos_ff[a] != nm1_ff[a]);
      end
      case (ax_ff)
         AX_Z:    ax_lo_ok = lo_ok[2];
         AX_Y:    ax_lo_ok = lo_ok[1];
         AX_X:    ax_lo_ok = lo_ok[0];
         default: ax_lo_ok = 1'b0;
      endcase
      rd_dist[0] = d_s_ff;
      rd_dist[1] = ax_lo_ok ? d_2s_ff : d_s_ff;
      rd_dist[2] = d_s_ff;
      rd_dist[3] = d_s_ff;
      rd_dist[4] = d_s_ff;
      rd_dist[5] = d_s_ff;
      if (ax_ff == AX_Y || ax_ff == AX_Z) begin
         rd_dist[2] = lo_ok[0] ? d_sp1_ff : d_s_ff;
         rd_dist[3] = hi_ok[0] ? d_sm1_ff : d_s_ff;
      end
      if (ax_ff == AX_Z) begin
         rd_dist[4] = lo_ok[1] ? d_spx_ff : d_s_ff;
         rd_dist[5] = hi_ok[1] ? d_smx_ff : d_s_ff;
      end
      push_entry.sample  = req_sample;
      push_entry.has_res = &ok;
      push_entry.last    = &at_last;
      push_entry.all_cur = (ax_ff == AX_NONE);
      push_entry.wr_addr = ring_ptr_ff;
      for (int i = 0; i < RD_PORTS; i++) begin
         push_entry.rd_addr[i] = ring_ptr_ff - rd_dist[i];
      end
   end

   // raster position and ring pointer
   always_comb begin
      for (int a = 0; a < 3; a++) pos_in[a] = pos_ff[a];
      ring_ptr_in = ring_ptr_ff;
      if (csr_we && csr_index <= CSR_SIZE_Z) begin
         for (int a = 0; a < 3; a++) pos_in[a] = '0;
      end else if (push) begin
         ring_ptr_in = ring_ptr_ff + RING_AW'(1);
         if (pos_ff[0] != nm1_ff[0]) begin
            pos_in[0] = pos_ff[0] + POS_W'(1);
         end else begin
            pos_in[0] = '0;
            if (pos_ff[1] != nm1_ff[1]) begin
               pos_in[1] = pos_ff[1] + POS_W'(1);
            end else begin
               pos_in[1] = '0;
               pos_in[2] = (pos_ff[2] != nm1_ff[2]) ? pos_ff[2] + POS_W'(1) : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= SIZE_RESET;
         size_y_ff   <= SIZE_RESET;
         size_z_ff   <= SIZE_RESET;
         settle_ff   <= 1'b1;
         ring_ptr_ff <= '0;
         for (int a = 0; a < 3; a++) pos_ff[a] <= '0;
      end else begin
         size_x_ff   <= size_x_in;
         size_y_ff   <= size_y_in;
         size_z_ff   <= size_z_in;
         settle_ff   <= csr_we;
         ring_ptr_ff <= ring_ptr_in;
         for (int a = 0; a < 3; a++) pos_ff[a] <= pos_in[a];
      end
   end

   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      d_s_ff   <= d_s_in;
      d_2s_ff  <= d_2s_in;
      d_sp1_ff <= d_sp1_in;
      d_sm1_ff <= d_sm1_in;
      d_spx_ff <= d_spx_in;
      d_smx_ff <= d_smx_in;
      for (int a = 0; a < 3; a++) begin
         nm1_ff[a] <= nm1_in[a];
         h_ff[a]   <= h_in[a];
         hm1_ff[a] <= hm1_in[a];
      end
   end

endmodule

// File: rtl/m7ds_back.sv
module m7ds_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  m7ds_pkg::entry_type                    head_entry,
   input  logic                                   q_not_empty,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [m7ds_pkg::SAMPLE_W-1:0]   rsp_median_value,
   output logic                                   rsp_last_out
);
   import m7ds_pkg::*;

   // three copies of the ring, two read ports each
   logic [SAMPLE_W-1:0] ring0 [RING_DEPTH];
   logic [SAMPLE_W-1:0] ring1 [RING_DEPTH];
   logic [SAMPLE_W-1:0] ring2 [RING_DEPTH];

   logic signed [SAMPLE_W-1:0] rd_data_ff [RD_PORTS];
   logic signed [SAMPLE_W-1:0] cur_ff;
   logic                       b_valid_ff, b_valid_in;
   logic                       b_last_ff;
   logic                       b_all_cur_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_median_ff;
   logic                       rsp_last_ff;

   logic                       out_free, b_go, b_accept, rd_en;
   logic signed [SAMPLE_W-1:0] taps [MED_TAPS];
   logic [2:0]                 rank [MED_TAPS];
   logic signed [SAMPLE_W-1:0] median;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_go     = b_valid_ff && out_free;
   assign b_accept = !b_valid_ff || b_go;
   // a transaction with no result only writes the ring
   assign q_pop    = q_not_empty && (!head_entry.has_res || b_accept);
   assign rd_en    = q_pop && head_entry.has_res;

   assign b_valid_in   = rd_en ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);
   assign rsp_valid_in = b_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ring0[head_entry.wr_addr] <= head_entry.sample;
         ring1[head_entry.wr_addr] <= head_entry.sample;
         ring2[head_entry.wr_addr] <= head_entry.sample;
      end
      if (rd_en) begin
         rd_data_ff[0] <= ring0[head_entry.rd_addr[0]];
         rd_data_ff[1] <= ring0[head_entry.rd_addr[1]];
         rd_data_ff[2] <= ring1[head_entry.rd_addr[2]];
         rd_data_ff[3] <= ring1[head_entry.rd_addr[3]];
         rd_data_ff[4] <= ring2[head_entry.rd_addr[4]];
         rd_data_ff[5] <= ring2[head_entry.rd_addr[5]];
         cur_ff        <= head_entry.sample;
         b_last_ff     <= head_entry.last;
         b_all_cur_ff  <= head_entry.all_cur;
      end
   end

   // rank each tap; equal values break ties by position
   always_comb begin
      for (int i = 0; i < RD_PORTS; i++) begin
         taps[i] = b_all_cur_ff ? cur_ff : rd_data_ff[i];
      end
      taps[MED_TAPS-1] = cur_ff;
      for (int i = 0; i < MED_TAPS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < MED_TAPS; j++) begin
            if (j != i && ((taps[j] < taps[i]) || (taps[j] == taps[i] && j < i))) begin
               rank[i] = rank[i] + 3'd1;
            end
         end
      end
      median = taps[0];
      for (int i = 0; i < MED_TAPS; i++) begin
         if (rank[i] == 3'(MED_RANK)) median = taps[i];
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         rsp_median_ff <= median;
         rsp_last_ff   <= b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_median_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule

// File: rtl/median7_volume_downsample_core.sv
// Median-of-seven 2x downsampler for a streamed 3D volume.
// req_* : one signed voxel per transaction, raster order (x fastest, then y, z).
// rsp_* : one median per downsampled voxel, raster order, rsp_last_out on the
//         final one of the volume. Both channels are valid/ready.
// csr_* : size_x, size_y, size_z at indexes 0..2; write only while idle. A
//         write restarts the volume position; req_ready drops for one cycle
//         while the derived geometry settles.
// Throughput: one voxel per cycle while the queue has room and no CSR write
// settles; the front classifies and computes six ring read addresses, a
// four-entry queue decouples it from the back, which reads three two-port
// copies of the sample ring and ranks the seven taps. A median passes from
// the queue through the ring read register, then the output register.
// Reset: position and ring pointer clear, sizes return to 256, req_ready is low
// for the first cycle. Ring contents are not cleared.
// rsp stall: the output register holds; the back stalls only on result-bearing
// transactions, and req_ready falls once the queue fills.
module median7_volume_downsample_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [m7ds_pkg::CSR_IW-1:0]            csr_index,
   input  logic [m7ds_pkg::SIZE_W-1:0]            csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [m7ds_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [m7ds_pkg::SAMPLE_W-1:0]   rsp_median_value,
   output logic                                   rsp_last_out
);
   import m7ds_pkg::*;

   logic      push, pop, q_full, q_not_empty;
   entry_type push_entry, head_entry;

   m7ds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   m7ds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   m7ds_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .q_not_empty      (q_not_empty),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_value (rsp_median_value),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// File: tb/median7_volume_downsample_core_test.sv
`timescale 1ns / 100ps

module median7_volume_downsample_core_test;
   import m7ds_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 8;
   localparam int RANDOM_GOAL = 880;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_IW-1:0]          csr_index;
   logic [SIZE_W-1:0]          csr_wdata;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_median_value;
   logic                       rsp_last_out;

   median7_volume_downsample_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_value (rsp_median_value),
      .rsp_last_out     (rsp_last_out)
   );

   // predictor state
   int ring_mem [RING_DEPTH];
   int ring_wr;
   int pos_col, pos_row, pos_plane;
   int vol_size [3];

   logic signed [SAMPLE_W-1:0] median_q [$];
   logic                       last_q [$];

   int err_count;
   int idle_cycles;
   int send_idle_pct;
   int stall_pct;
   int samples_sent;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("mismatch: %s", msg);
      err_count++;
   endtask

   function automatic int clamp_size(input int v);
      if (v < 1) return 1;
      if (v > SIZE_LIMIT) return SIZE_LIMIT;
      return v;
   endfunction

   function automatic int ring_read(input longint back_dist, input int cur);
      longint back;
      if (back_dist == 0) return cur;
      back = back_dist % RING_DEPTH;
      return ring_mem[(ring_wr + RING_DEPTH - back) % RING_DEPTH];
   endfunction

   // work out the median (if any) caused by one voxel, then advance position
   function automatic void predict_median(input logic signed [SAMPLE_W-1:0] s);
      int n [3];
      int h [3];
      int c [3];
      int cc [3];
      int p [3];
      int taps [7];
      int ax, k, t, j;
      bit fires, is_last;
      longint sx, sxy, here;
      fires = 1'b1;
      for (int a = 0; a < 3; a++) begin
         n[a] = clamp_size(vol_size[a]);
         h[a] = (n[a] / 2 < 1) ? 1 : n[a] / 2;
      end
      c[0] = pos_col; c[1] = pos_row; c[2] = pos_plane;
      ax = (n[2] >= 2) ? 2 : (n[1] >= 2) ? 1 : (n[0] >= 2) ? 0 : -1;
      for (int a = 0; a < 3; a++) begin
         if (a == ax) begin
            if (c[a][0] == 1'b0 || (c[a] - 1) / 2 >= h[a]) fires = 1'b0;
            cc[a] = c[a] - 1;
         end else begin
            if (c[a][0] == 1'b1 || c[a] / 2 >= h[a]) fires = 1'b0;
            cc[a] = c[a];
         end
      end
      if (fires) begin
         sx = n[0];
         sxy = longint'(n[0]) * n[1];
         here = c[0] + c[1] * sx + c[2] * sxy;
         taps[0] = ring_read(here - (cc[0] + cc[1] * sx + cc[2] * sxy), int'(s));
         k = 1;
         for (int a = 0; a < 3; a++) begin
            p = cc;
            p[a] = (cc[a] > 0) ? cc[a] - 1 : 0;
            taps[k++] = ring_read(here - (p[0] + p[1] * sx + p[2] * sxy), int'(s));
            p[a] = (cc[a] + 1 < n[a]) ? cc[a] + 1 : n[a] - 1;
            taps[k++] = ring_read(here - (p[0] + p[1] * sx + p[2] * sxy), int'(s));
         end
         for (int a = 1; a < 7; a++) begin
            t = taps[a];
            j = a - 1;
            while (j >= 0 && taps[j] > t) begin
               taps[j + 1] = taps[j];
               j--;
            end
            taps[j + 1] = t;
         end
         is_last = (cc[0] / 2 == h[0] - 1) && (cc[1] / 2 == h[1] - 1) &&
                   (cc[2] / 2 == h[2] - 1);
         median_q.push_back(SAMPLE_W'(taps[3]));
         last_q.push_back(is_last);
      end
      ring_mem[ring_wr] = int'(s);
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      pos_col++;
      if (pos_col >= n[0]) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= n[1]) begin
            pos_row = 0;
            pos_plane++;
            if (pos_plane >= n[2]) pos_plane = 0;
         end
      end
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         ring_wr = 0;
         pos_col = 0;
         pos_row = 0;
         pos_plane = 0;
         vol_size = '{256, 256, 256};
         idle_cycles <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SIZE_X: vol_size[0] = int'(csr_wdata);
               CSR_SIZE_Y: vol_size[1] = int'(csr_wdata);
               CSR_SIZE_Z: vol_size[2] = int'(csr_wdata);
               default: ;
            endcase
            if (csr_index <= CSR_SIZE_Z) begin
               pos_col = 0;
               pos_row = 0;
               pos_plane = 0;
            end
         end
         if (req_valid && req_ready) predict_median(req_sample);
         if (rsp_valid && rsp_ready) begin
            if (median_q.size() == 0) begin
               report_error($sformatf("unexpected median %0d", rsp_median_value));
            end else begin
               if (rsp_median_value !== median_q[0])
                  report_error($sformatf("median got %0d want %0d",
                                         rsp_median_value, median_q[0]));
               if (rsp_last_out !== last_q[0])
                  report_error($sformatf("last_out got %b want %b",
                                         rsp_last_out, last_q[0]));
               void'(median_q.pop_front());
               void'(last_q.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample = s;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      samples_sent++;
   endtask

   // let outstanding medians drain before touching the registers
   task automatic wait_drained();
      req_valid = 1'b0;
      while (median_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_size(input logic [CSR_IW-1:0] idx, input int v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = SIZE_W'(v);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_volume(input int x, input int y, input int z);
      wait_drained();
      write_size(CSR_SIZE_X, x);
      write_size(CSR_SIZE_Y, y);
      write_size(CSR_SIZE_Z, z);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(3))
         0: return SAMPLE_W'($urandom_range(7)) - 16'sd4;
         1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [SAMPLE_W-1:0] edge_vals [8];
      edge_vals = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh7FFE,
                    16'sh8001, 16'sd0};
      // 2x2x2: single output, trigger on the z axis
      set_volume(2, 2, 2);
      foreach (edge_vals[i]) send_sample(edge_vals[i]);
      // sizes of zero act as one: every voxel is its own median
      set_volume(0, 0, 0);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(-16'sd1);
      // odd sizes on the y trigger axis, trailing row and column dropped
      set_volume(3, 3, 1);
      for (int i = 0; i < 9; i++) send_sample(edge_vals[i % 8]);
      // x axis as trigger
      set_volume(4, 1, 1);
      for (int i = 0; i < 4; i++) send_sample(edge_vals[7 - i]);
   endtask

   task automatic test_size_extremes();
      // oversized values clamp to the largest size; send only a partial volume
      set_volume(2047, 1, 1);
      for (int i = 0; i < 40; i++) send_sample(pick_sample());
      set_volume(1, 1024, 1);
      for (int i = 0; i < 40; i++) send_sample(pick_sample());
      set_volume(1, 1, 1500);
      for (int i = 0; i < 40; i++) send_sample(pick_sample());
      set_volume(64, 1024, 2);
      for (int i = 0; i < 30; i++) send_sample(pick_sample());
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(12, 7);
      return $urandom_range(6, 1);
   endfunction

   task automatic test_random_volumes(input int idle_in, input int stall_in,
                                      input int goal);
      int x, y, z, total, cut;
      send_idle_pct = idle_in;
      stall_pct = stall_in;
      goal += samples_sent;
      while (samples_sent < goal) begin
         x = pick_size();
         y = pick_size();
         z = pick_size();
         set_volume(x, y, z);
         total = clamp_size(x) * clamp_size(y) * clamp_size(z);
         // mostly whole volumes, sometimes two back to back, sometimes cut short
         case ($urandom_range(9))
            0: total = total * 2;
            1: total = $urandom_range(total, 1);
            default: ;
         endcase
         for (int i = 0; i < total && samples_sent < goal; i++) send_sample(pick_sample());
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SIZE_X;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_sample = '0;
      err_count = 0;
      samples_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_size_extremes();
      test_random_volumes(0, 0, RANDOM_GOAL / 4);
      test_random_volumes(65, 0, RANDOM_GOAL / 4);
      test_random_volumes(0, 65, RANDOM_GOAL / 4);
      test_random_volumes(35, 35, RANDOM_GOAL / 4);
      wait_drained();
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
